/* sv/mlptw_pkg.sv */
// Package for the multilevel page table walker: sizes, codes and the
// command/status structs shared by controller and datapath.
// No dependencies.
package mlptw_pkg;

  // Walk geometry
  localparam int LEVELS   = 5;
  localparam int FRAMES   = 64;
  localparam int IDX_W    = 9;
  localparam int ENTRIES  = 1 << IDX_W;

  // Derived sizes
  localparam int FRAME_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int ADDR_W   = FRAME_W + IDX_W;
  localparam int DEPTH    = FRAMES * ENTRIES;
  localparam int VPN_W    = IDX_W * LEVELS;
  localparam int LVL_W    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int USED_W   = $clog2(FRAMES + 1);

  // Field widths
  localparam int KIND_W   = 2;
  localparam int VPN_IN_W = 45;
  localparam int PPN_W    = 52;
  localparam int STAT_W   = 2;
  localparam int ENTRY_W  = PPN_W + 1;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;
  localparam int SUM_W      = ((CFG_DATA_W > USED_W) ? CFG_DATA_W : USED_W) + 1;

  localparam logic [CFG_IDX_W-1:0]  CFG_ROOT       = 1'd0;
  localparam logic [CFG_IDX_W-1:0]  CFG_FIRST_FREE = 1'd1;
  localparam logic [CFG_DATA_W-1:0] ROOT_RST       = 6'd0;
  localparam logic [CFG_DATA_W-1:0] FIRST_FREE_RST = 6'd1;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MAP   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_UNMAP = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOFRAME = 2'd1;
  localparam logic [STAT_W-1:0] ST_BADPTR  = 2'd2;

  // Store write source
  typedef enum logic [2:0] {
    WR_NONE,
    WR_CLR,
    WR_ZERO,
    WR_LINK,
    WR_MAP,
    WR_UNMAP
  } wr_op_t;

  // Controller to datapath
  typedef struct packed {
    logic              load;        // input transfer
    logic              rd_issue;    // read entry at current level
    logic              descend;     // follow the entry just read
    logic              alloc_start; // claim a new frame, start zeroing
    logic              link;        // follow the new frame
    wr_op_t            wr_op;
    logic              set_res;
    logic [STAT_W-1:0] res_status;
    logic              res_mapped;
    logic              publish;     // move result into output register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              root_bad;
    logic              ent_valid;
    logic              last_lvl;
    logic              next_bad;
    logic              nf_bad;
    logic              clr_last;
    logic              zero_last;
    logic              out_busy;
  } dp_stat_t;

endpackage

/* sv/mlptw_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module mlptw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/mlptw_ctrl.sv */
// Walk controller: one-hot state machine sequencing clear, walk, allocation
// and result hand-off. Depends on mlptw_pkg.
module mlptw_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  mlptw_pkg::dp_stat_t st,
  output mlptw_pkg::dp_cmd_t  cmd
);
  import mlptw_pkg::*;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_START = 8'b0000_0100,
    S_READ  = 8'b0000_1000,
    S_EVAL  = 8'b0001_0000,
    S_ZERO  = 8'b0010_0000,
    S_LINK  = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.wr_op = WR_NONE;
    case (state_r)
      S_CLEAR: begin
        cmd.wr_op = WR_CLR;
        if (st.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_START;
        end
      end
      S_START: begin
        if (st.kind != KIND_QUERY && st.kind != KIND_MAP && st.kind != KIND_UNMAP) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = ST_OK;
          state_nxt      = S_FIN;
        end else if (st.root_bad) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = ST_BADPTR;
          state_nxt      = S_FIN;
        end else begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_EVAL;
      end
      S_EVAL: begin
        if (st.last_lvl) begin
          // leaf entry
          cmd.set_res    = 1'b1;
          cmd.res_status = ST_OK;
          state_nxt      = S_FIN;
          if (st.kind == KIND_QUERY) begin
            cmd.res_mapped = st.ent_valid;
          end else if (st.kind == KIND_MAP) begin
            cmd.wr_op = WR_MAP;
          end else begin
            cmd.wr_op = WR_UNMAP;
          end
        end else if (st.ent_valid) begin
          if (st.next_bad) begin
            cmd.set_res    = 1'b1;
            cmd.res_status = ST_BADPTR;
            state_nxt      = S_FIN;
          end else begin
            cmd.descend = 1'b1;
            state_nxt   = S_READ;
          end
        end else if (st.kind != KIND_MAP) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = ST_OK;
          state_nxt      = S_FIN;
        end else if (st.nf_bad) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = ST_NOFRAME;
          state_nxt      = S_FIN;
        end else begin
          cmd.alloc_start = 1'b1;
          state_nxt       = S_ZERO;
        end
      end
      S_ZERO: begin
        cmd.wr_op = WR_ZERO;
        if (st.zero_last) begin
          state_nxt = S_LINK;
        end
      end
      S_LINK: begin
        cmd.wr_op = WR_LINK;
        cmd.link  = 1'b1;
        state_nxt = S_READ;
      end
      S_FIN: begin
        if (!st.out_busy) begin
          cmd.publish = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  // a result is only staged while an item is in flight
  a_res_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.set_res |-> (state_r == S_START || state_r == S_EVAL))
    else $error("result staged outside a walk");

  // every read is evaluated on the following cycle
  a_read_eval: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_issue |=> state_r == S_EVAL)
    else $error("read not followed by evaluation");

  // zeroing sweep always ends in a link write
  a_zero_link: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ZERO && st.zero_last) |=> cmd.wr_op == WR_LINK)
    else $error("new frame not linked after zeroing");
`endif

endmodule

/* sv/mlptw_dpath.sv */
// Walk datapath: configuration, item registers, level walk, frame allocator,
// table store and result/output registers. Depends on mlptw_pkg, mlptw_ram.
module mlptw_dpath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [mlptw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mlptw_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic [mlptw_pkg::KIND_W-1:0]        in_kind,
  input  logic [mlptw_pkg::VPN_IN_W-1:0]      in_vpn,
  input  logic [mlptw_pkg::PPN_W-1:0]         in_ppn,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_mapped,
  output logic [mlptw_pkg::PPN_W-1:0]         out_frame_out,
  output logic [mlptw_pkg::STAT_W-1:0]        out_status,
  input  mlptw_pkg::dp_cmd_t                  cmd,
  output mlptw_pkg::dp_stat_t                 st
);
  import mlptw_pkg::*;

  logic [CFG_DATA_W-1:0] root_frame_r;
  logic [CFG_DATA_W-1:0] first_free_r;
  logic [KIND_W-1:0]     kind_r;
  logic [VPN_W-1:0]      vpn_r;
  logic [PPN_W-1:0]      ppn_r;
  logic [FRAME_W-1:0]    cur_r;
  logic [FRAME_W-1:0]    nf_r;
  logic [LVL_W-1:0]      lvl_r;
  logic [ADDR_W-1:0]     slot_r;
  logic [ADDR_W-1:0]     sweep_r;
  logic [USED_W-1:0]     frames_used_r;
  logic                  res_mapped_r;
  logic [PPN_W-1:0]      res_frame_r;
  logic [STAT_W-1:0]     res_status_r;
  logic                  out_valid_r;
  logic                  out_mapped_r;
  logic [PPN_W-1:0]      out_frame_r;
  logic [STAT_W-1:0]     out_status_r;

  logic [ADDR_W-1:0]     raddr;
  logic [ENTRY_W-1:0]    rdata;
  logic                  we;
  logic [ADDR_W-1:0]     waddr;
  logic [ENTRY_W-1:0]    wdata;
  logic [PPN_W-1:0]      ent_frame;
  logic [SUM_W-1:0]      nf_sum;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_frame_r <= ROOT_RST;
      first_free_r <= FIRST_FREE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROOT:       root_frame_r <= cfg_wdata;
        CFG_FIRST_FREE: first_free_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // walk address and checks
  assign raddr     = {cur_r, vpn_r[VPN_W-1 -: IDX_W]};
  assign ent_frame = rdata[ENTRY_W-1:1];
  assign nf_sum    = SUM_W'(first_free_r) + SUM_W'(frames_used_r);

  assign st.kind      = kind_r;
  assign st.root_bad  = 32'(root_frame_r) >= 32'(FRAMES);
  assign st.ent_valid = rdata[0];
  assign st.last_lvl  = (lvl_r == LVL_W'(LEVELS - 1));
  assign st.next_bad  = ent_frame >= PPN_W'(FRAMES);
  assign st.nf_bad    = nf_sum >= SUM_W'(FRAMES);
  assign st.clr_last  = (sweep_r == ADDR_W'(DEPTH - 1));
  assign st.zero_last = (sweep_r[IDX_W-1:0] == IDX_W'(ENTRIES - 1));
  assign st.out_busy  = out_valid_r && !out_ready;

  // item and walk registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      vpn_r  <= in_vpn[VPN_W-1:0];
      ppn_r  <= in_ppn;
      cur_r  <= FRAME_W'(root_frame_r);
      lvl_r  <= '0;
    end else if (cmd.descend) begin
      cur_r  <= ent_frame[FRAME_W-1:0];
      lvl_r  <= lvl_r + 1'b1;
      vpn_r  <= vpn_r << IDX_W;
    end else if (cmd.link) begin
      cur_r  <= nf_r;
      lvl_r  <= lvl_r + 1'b1;
      vpn_r  <= vpn_r << IDX_W;
    end
    if (cmd.rd_issue) begin
      slot_r <= raddr;
    end
    if (cmd.alloc_start) begin
      nf_r <= nf_sum[FRAME_W-1:0];
    end
  end

  // allocator count and sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_used_r <= '0;
      sweep_r       <= '0;
    end else begin
      if (cmd.alloc_start) begin
        frames_used_r <= frames_used_r + 1'b1;
        sweep_r       <= '0;
      end else if (cmd.wr_op == WR_CLR || cmd.wr_op == WR_ZERO) begin
        sweep_r <= sweep_r + 1'b1;
      end
    end
  end

  // store write source
  always_comb begin
    we    = 1'b1;
    waddr = slot_r;
    wdata = '0;
    case (cmd.wr_op)
      WR_CLR:   waddr = sweep_r;
      WR_ZERO:  waddr = {nf_r, sweep_r[IDX_W-1:0]};
      WR_LINK:  wdata = {PPN_W'(nf_r), 1'b1};
      WR_MAP:   wdata = {ppn_r, 1'b1};
      WR_UNMAP: wdata = {ent_frame, 1'b0};
      default:  we    = 1'b0;
    endcase
  end

  mlptw_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd_issue),
    .raddr (raddr),
    .rdata (rdata)
  );

  // staged result
  always_ff @(posedge clk) begin
    if (cmd.set_res) begin
      res_mapped_r <= cmd.res_mapped;
      res_frame_r  <= cmd.res_mapped ? ent_frame : '0;
      res_status_r <= cmd.res_status;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.publish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.publish) begin
      out_mapped_r <= res_mapped_r;
      out_frame_r  <= res_frame_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_mapped    = out_mapped_r;
  assign out_frame_out = out_frame_r;
  assign out_status    = out_status_r;

`ifndef SYNTHESIS
  // a new result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |-> (!out_valid_r || out_ready))
    else $error("result overwritten before transfer");

  // allocator stays within the store
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(frames_used_r) <= 32'(FRAMES))
    else $error("frame count beyond store");

  // only in-range frames are walked
  a_cur_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_issue |-> 32'(cur_r) < 32'(FRAMES))
    else $error("walk pointer outside store");

  // a frame is claimed only when one is left
  a_alloc_ok: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.alloc_start |=> 32'(nf_r) < 32'(FRAMES))
    else $error("allocated frame outside store");
`endif

endmodule

/* sv/multilevel_page_table_walker.sv */
// Radix page table walker, top level: joins controller and datapath.
// Depends on mlptw_pkg, mlptw_ctrl, mlptw_dpath (and mlptw_ram below it).
//
// After reset the block sweeps its frame store clear, one entry a cycle,
// before in_ready first rises; configuration writes are taken throughout.
// Items are then handled one at a time: in_ready is low from the transfer
// of an item until its result moves into the output register. Each level
// of a walk is a read of the store with registered read data, then an
// evaluation step. A walk that stops early reads fewer levels. Each
// intermediate table that a map allocates lengthens the walk: the new frame
// is zeroed one entry a cycle, then the pointer is written. The next item
// is taken while a result waits in the output register.
module multilevel_page_table_walker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [mlptw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mlptw_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [mlptw_pkg::KIND_W-1:0]        in_kind,
  input  logic [mlptw_pkg::VPN_IN_W-1:0]      in_vpn,
  input  logic [mlptw_pkg::PPN_W-1:0]         in_ppn,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_mapped,
  output logic [mlptw_pkg::PPN_W-1:0]         out_frame_out,
  output logic [mlptw_pkg::STAT_W-1:0]        out_status
);
  import mlptw_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t st;

  mlptw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  mlptw_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_kind       (in_kind),
    .in_vpn        (in_vpn),
    .in_ppn        (in_ppn),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_mapped    (out_mapped),
    .out_frame_out (out_frame_out),
    .out_status    (out_status),
    .cmd           (cmd),
    .st            (st)
  );

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the five-level page table walker.
// Depends on mlptw_pkg and the multilevel_page_table_walker RTL; a shadow
// frame store in the bench predicts every result of the walk.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mlptw_pkg::*;

  // Spare kind code: the block must answer it with an all-zero result
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int PHASE_ITEMS = 100;
  localparam int SINK_HOLD_CYCLES = 400;

  typedef struct packed {
    logic              mapped;
    logic [PPN_W-1:0]  frame;
    logic [STAT_W-1:0] status;
  } walk_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  logic [KIND_W-1:0]     in_kind;
  logic [VPN_IN_W-1:0]   in_vpn;
  logic [PPN_W-1:0]      in_ppn;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_mapped;
  logic [PPN_W-1:0]      out_frame_out;
  logic [STAT_W-1:0]     out_status;

  multilevel_page_table_walker u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_vpn        (in_vpn),
    .in_ppn        (in_ppn),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_mapped    (out_mapped),
    .out_frame_out (out_frame_out),
    .out_status    (out_status)
  );

  // Shadow copy of the block's state and registers
  logic [ENTRY_W-1:0]    shadow_store [DEPTH];
  int unsigned           shadow_used;
  logic [CFG_DATA_W-1:0] shadow_root;
  logic [CFG_DATA_W-1:0] shadow_first_free;

  walk_result_t pending_results [$];
  int           mismatch_count;

  // Sender and receiver pacing
  bit           burst_mode;
  bit           valid_held;
  int           queued_gap;
  int           sink_hold_req;

  // Random vpns grow from these bases so walks reach existing tables
  logic [VPN_IN_W-1:0] vpn_pool [16];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Idle length: mostly short, now and then long, none in burst mode
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst_mode) return 0;
    if (r < 80) return $urandom_range(0, 3);
    if (r < 95) return $urandom_range(4, 20);
    return $urandom_range(40, 150);
  endfunction

  // Walk the shadow store for one item, updating it as the block would
  function automatic walk_result_t walk_table(input logic [KIND_W-1:0] kind,
                                              input logic [VPN_IN_W-1:0] vpn,
                                              input logic [PPN_W-1:0] ppn);
    walk_result_t     res;
    logic [PPN_W-1:0] cur;
    logic [ENTRY_W-1:0] ent;
    logic [IDX_W-1:0] idx;
    int unsigned      nf;
    int               addr;
    int               lv;
    int               j;
    bit               stop;
    res = '0;
    if (kind == KIND_UNUSED) return res;
    cur = PPN_W'(shadow_root);
    stop = 1'b0;
    if (cur >= FRAMES) begin
      res.status = ST_BADPTR;
      stop = 1'b1;
    end
    for (lv = 0; lv < LEVELS - 1 && !stop; lv++) begin
      idx = vpn[IDX_W*(LEVELS-1-lv) +: IDX_W];
      addr = int'(cur) * ENTRIES + int'(idx);
      ent = shadow_store[addr];
      if (!ent[0] && kind != KIND_MAP) begin
        stop = 1'b1;
      end else begin
        // Map through a hole: hand out the next frame, zeroed
        if (!ent[0]) begin
          nf = int'(shadow_first_free) + shadow_used;
          if (nf >= FRAMES) begin
            res.status = ST_NOFRAME;
            stop = 1'b1;
          end else begin
            for (j = 0; j < ENTRIES; j++) shadow_store[nf*ENTRIES + j] = '0;
            shadow_used++;
            ent = {PPN_W'(nf), 1'b1};
            shadow_store[addr] = ent;
          end
        end
        if (!stop) begin
          cur = ent[ENTRY_W-1:1];
          if (cur >= FRAMES) begin
            res.status = ST_BADPTR;
            stop = 1'b1;
          end
        end
      end
    end
    // Leaf level
    if (!stop) begin
      idx = vpn[IDX_W-1:0];
      addr = int'(cur) * ENTRIES + int'(idx);
      ent = shadow_store[addr];
      if (kind == KIND_QUERY) begin
        if (ent[0]) begin
          res.mapped = 1'b1;
          res.frame = ent[ENTRY_W-1:1];
        end
      end else if (kind == KIND_MAP) begin
        shadow_store[addr] = {ppn, 1'b1};
      end else begin
        shadow_store[addr] = {ent[ENTRY_W-1:1], 1'b0};
      end
    end
    return res;
  endfunction

  // One input transfer; valid stays up if the next item follows at once
  task automatic send_item(input logic [KIND_W-1:0] kind,
                           input logic [VPN_IN_W-1:0] vpn,
                           input logic [PPN_W-1:0] ppn);
    if (!valid_held) repeat (queued_gap) @(posedge clk);
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_vpn   <= vpn;
    in_ppn   <= ppn;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(walk_table(kind, vpn, ppn));
    queued_gap = pick_gap();
    valid_held = (queued_gap == 0);
    if (!valid_held) in_valid <= 1'b0;
  endtask

  // Drop valid, then wait until every result has been taken
  task automatic wait_idle();
    if (valid_held) begin
      in_valid <= 1'b0;
      valid_held = 1'b0;
    end
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == CFG_ROOT) shadow_root = val;
    else shadow_first_free = val;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] root,
                           input logic [CFG_DATA_W-1:0] first_free);
    wait_idle();
    write_reg(CFG_ROOT, root);
    write_reg(CFG_FIRST_FREE, first_free);
  endtask

  function automatic logic [PPN_W-1:0] pick_ppn();
    logic [63:0] raw;
    int r;
    raw = {$urandom, $urandom};
    r = $urandom_range(0, 99);
    if (r < 70) return raw[PPN_W-1:0];
    if (r < 90) return PPN_W'($urandom_range(0, FRAMES - 1));
    return r[0] ? '1 : '0;
  endfunction

  function automatic logic [VPN_IN_W-1:0] pick_vpn();
    logic [63:0] raw;
    logic [VPN_IN_W-1:0] v;
    int r;
    raw = {$urandom, $urandom};
    r = $urandom_range(0, 99);
    v = vpn_pool[$urandom_range(0, 15)];
    if (r < 10) v = raw[VPN_IN_W-1:0];
    else if (r < 55) v = v;
    else if (r < 85) v[IDX_W-1:0] = raw[IDX_W-1:0];
    else if (r < 95) v[2*IDX_W-1:0] = raw[2*IDX_W-1:0];
    else v[3*IDX_W-1:0] = raw[3*IDX_W-1:0];
    return v;
  endfunction

  function automatic logic [KIND_W-1:0] pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 38) return KIND_MAP;
    if (r < 78) return KIND_QUERY;
    if (r < 94) return KIND_UNMAP;
    return KIND_UNUSED;
  endfunction

  // Basic map/query/unmap over an empty store
  task automatic test_directed_walks();
    logic [VPN_IN_W-1:0] top_only;
    top_only = VPN_IN_W'(1) << (IDX_W * (LEVELS - 1));
    configure(ROOT_RST, FIRST_FREE_RST);
    send_item(KIND_QUERY, '0, '0);              // empty store
    send_item(KIND_UNMAP, '0, '1);              // absent mapping
    send_item(KIND_MAP,   '0, '1);              // allocates four tables
    send_item(KIND_QUERY, '0, '0);
    send_item(KIND_MAP,   VPN_IN_W'(1), '0);    // same leaf table, frame zero
    send_item(KIND_QUERY, VPN_IN_W'(1), '1);
    send_item(KIND_MAP,   '1, {(PPN_W/2){2'b01}});
    send_item(KIND_QUERY, '1, '0);
    send_item(KIND_QUERY, top_only, '0);        // stops at the root
    send_item(KIND_MAP,   VPN_IN_W'(1) << IDX_W, PPN_W'(2));
    send_item(KIND_UNMAP, '1, '0);
    send_item(KIND_QUERY, '1, '0);
    send_item(KIND_UNMAP, '1, '0);              // leaf already invalid
    send_item(KIND_MAP,   '1, {(PPN_W/2){2'b10}});
    send_item(KIND_QUERY, '1, '0);
    send_item(KIND_UNUSED, '0, '1);
    send_item(KIND_QUERY, '0, '0);
    send_item(KIND_UNMAP, top_only, '0);
  endtask

  // Root moved onto the leaf table of vpn 0 (frame 4): its entries become
  // pointers, one far outside the store and one back to frame 0
  task automatic test_foreign_root();
    logic [VPN_IN_W-1:0] top_only;
    top_only = VPN_IN_W'(1) << (IDX_W * (LEVELS - 1));
    configure(CFG_DATA_W'(4), FIRST_FREE_RST);
    send_item(KIND_QUERY, '0, '0);
    send_item(KIND_MAP,   '0, PPN_W'(7));
    send_item(KIND_UNMAP, '0, '0);
    send_item(KIND_QUERY, top_only, '0);
    configure(ROOT_RST, FIRST_FREE_RST);
  endtask

  // Random items in phases; the registers are set anew before each phase
  task automatic test_random_walks();
    logic [VPN_IN_W-1:0] hi_part [3];
    logic [63:0] raw;
    int phase;
    int i;
    hi_part[0] = '0;
    for (i = 1; i < 3; i++) begin
      raw = {$urandom, $urandom};
      hi_part[i] = raw[VPN_IN_W-1:0];
    end
    for (i = 0; i < 16; i++) begin
      raw = {$urandom, $urandom};
      vpn_pool[i] = {hi_part[i % 3][VPN_IN_W-1:3*IDX_W], raw[3*IDX_W-1:0]};
    end
    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        1:       configure(ROOT_RST, CFG_DATA_W'($urandom_range(1, 8)));
        2:       configure(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
        4:       configure('1, '0);
        6:       configure(CFG_DATA_W'($urandom), '1);
        default: configure(ROOT_RST, FIRST_FREE_RST);
      endcase
      burst_mode = phase[0];
      for (i = 0; i < PHASE_ITEMS; i++) send_item(pick_kind(), pick_vpn(), pick_ppn());
    end
    burst_mode = 1'b0;
  endtask

  // Receiver stalls for a long stretch while items keep coming
  task automatic test_output_backpressure();
    int i;
    configure(ROOT_RST, FIRST_FREE_RST);
    burst_mode = 1'b1;
    sink_hold_req = SINK_HOLD_CYCLES;
    for (i = 0; i < 24; i++) begin
      send_item(i[0] ? KIND_QUERY : KIND_MAP, vpn_pool[i % 16], pick_ppn());
    end
    burst_mode = 1'b0;
  endtask

  // Allocation past the last frame, and reuse of frames already in use
  task automatic test_frame_exhaustion();
    logic [63:0] raw;
    logic [VPN_IN_W-1:0] fresh [4];
    int i;
    for (i = 0; i < 4; i++) begin
      raw = {$urandom, $urandom};
      fresh[i] = raw[VPN_IN_W-1:0];
    end
    configure(ROOT_RST, '1);
    for (i = 0; i < 2; i++) send_item(KIND_MAP, fresh[i], pick_ppn());
    send_item(KIND_QUERY, fresh[0], '0);
    configure(ROOT_RST, '0);
    for (i = 0; i < 4; i++) send_item(KIND_MAP, fresh[i], pick_ppn());
    for (i = 0; i < 4; i++) send_item(KIND_QUERY, fresh[i], '0);
    send_item(KIND_UNMAP, fresh[3], '0);
    send_item(KIND_QUERY, fresh[3], '0);
    configure(ROOT_RST, FIRST_FREE_RST);
  endtask

  // Result checker and receiver pacing
  initial begin : result_sink
    walk_result_t want;
    int hold_left;
    int idle_left;
    hold_left = 0;
    idle_left = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result: mapped %0b frame %h status %0d",
                     out_mapped, out_frame_out, out_status);
        end else begin
          want = pending_results.pop_front();
          if (out_mapped !== want.mapped || out_frame_out !== want.frame ||
              out_status !== want.status) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: expected mapped %0b frame %h status %0d, got %0b %h %0d",
                       want.mapped, want.frame, want.status,
                       out_mapped, out_frame_out, out_status);
          end
        end
      end
      if (sink_hold_req != 0) begin
        hold_left = sink_hold_req;
        sink_hold_req = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (idle_left != 0) begin
        idle_left--;
        out_ready <= 1'b0;
      end else begin
        if ($urandom_range(0, 5) == 0) idle_left = pick_gap();
        out_ready <= (idle_left == 0);
      end
    end
  end

  // Watchdog
  initial begin
    #8_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  initial begin
    int i;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_kind   = '0;
    in_vpn    = '0;
    in_ppn    = '0;
    out_ready = 1'b0;
    mismatch_count = 0;
    burst_mode = 1'b0;
    valid_held = 1'b0;
    queued_gap = 0;
    sink_hold_req = 0;
    for (i = 0; i < DEPTH; i++) shadow_store[i] = '0;
    shadow_used = 0;
    shadow_root = ROOT_RST;
    shadow_first_free = FIRST_FREE_RST;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_walks();
    test_foreign_root();
    test_random_walks();
    test_output_backpressure();
    test_frame_exhaustion();

    wait_idle();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/mlptw_pkg.sv
sv/mlptw_ram.sv
sv/mlptw_ctrl.sv
sv/mlptw_dpath.sv
sv/multilevel_page_table_walker.sv
tb/testbench.sv
